/* design/at_response_line_parser_top_assert.svh */
// ----------------------------------------------------------------------------
// AT response line parser assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_LINE_PARSER_TOP_ASSERT_SVH
`define AT_RESPONSE_LINE_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define ALP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alp assertion failed");

// next-cycle implication
`define ALP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alp assertion failed");

`endif

/* design/alp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response line parser package
// Item types, line kinds, character codes and register map.
// ----------------------------------------------------------------------------
package alp_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} alp_in_t;

	typedef struct packed {
		logic [1:0]  line_kind;
		logic [7:0]  line_length;
		logic [15:0] error_code;
		logic        line_overflow;
	} alp_out_t;

	typedef struct packed {
		logic     done;
		alp_out_t item;
	} alp_res_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_OK    = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_OTHER = 2'd3
	} alp_kind_t;

	localparam logic       FUNC_BYTE   = 1'b0;
	localparam logic       FUNC_TICK   = 1'b1;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_R        = 8'h52;
	localparam logic [7:0] DIGIT_BASE  = 8'd48;
	localparam logic [15:0] OK_WORD    = 16'h4F4B;
	localparam logic [31:0] ERRO_WORD  = 32'h4552524F;
	localparam int         CODE_OFFSET = 3;

	localparam int          ADDR_W        = 3;
	localparam int          DATA_W        = 32;
	localparam logic        REG_GAP_LIMIT = 1'b0;
	localparam logic [15:0] GAP_LIMIT_RST = 16'd50;

endpackage

/* design/at_response_line_parser_top.sv */
`timescale 1ns / 1ps
// A line-ending item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register only holds when a line
// end meets a full, stalled result register.
// Reset: asynchronous, clears line state, silence count and the valid bits of both
// registers; the gap limit returns to 50 tick items.
// ----------------------------------------------------------------------------
// AT response line parser top level
// Input register, line state update, result register and register port.
// ----------------------------------------------------------------------------
module at_response_line_parser_top #(
	parameter int LINE_BYTES = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  alp_pkg::alp_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output alp_pkg::alp_out_t          out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [alp_pkg::ADDR_W-1:0] paddr,
	input  logic [alp_pkg::DATA_W-1:0] pwdata,
	output logic [alp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import alp_pkg::*;

	logic        valid_s1;
	alp_in_t     item_s1;
	logic        out_valid_q;
	alp_out_t    out_data_q;
	logic        out_ready, fire;
	logic [15:0] gap_limit;
	alp_res_t    res;

	alp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.gap_limit (gap_limit)
	);

	alp_parse #(
		.LINE_BYTES (LINE_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.gap_limit (gap_limit),
		.res       (res)
	);

	assign out_ready = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && (!res.done || out_ready);
	assign in_stall  = valid_s1 && !fire;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= fire && res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && fire && res.done) begin
			out_data_q <= res.item;
		end
	end

endmodule

/* design/alp_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response line parser register file
// APB-style port holding the silence gap limit.
// ----------------------------------------------------------------------------
module alp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [alp_pkg::ADDR_W-1:0]    paddr,
	input  logic [alp_pkg::DATA_W-1:0]    pwdata,
	output logic [alp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output logic [15:0]                   gap_limit
);
	import alp_pkg::*;

	logic        reg_idx;
	logic        wr_en;
	logic [15:0] gap_limit_q;

	assign reg_idx   = paddr[ADDR_W-1];
	assign wr_en     = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign gap_limit = gap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (wr_en && reg_idx == REG_GAP_LIMIT) begin
			gap_limit_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GAP_LIMIT: prdata = {{(DATA_W-16){1'b0}}, gap_limit_q};
			default:       prdata = '0;
		endcase
	end

endmodule

/* design/alp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response line parser line state
// Per-item line state update and line-end result decode.
// ----------------------------------------------------------------------------
module alp_parse #(
	parameter int LINE_BYTES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  alp_pkg::alp_in_t item,
	input  logic [15:0]      gap_limit,
	output alp_pkg::alp_res_t res
);
	import alp_pkg::*;

	localparam int POS_W = $clog2(LINE_BYTES + 2);
	localparam int CS_W  = $clog2(LINE_BYTES + 3);
	localparam logic [POS_W-1:0] POS_CAP  = POS_W'(LINE_BYTES);
	localparam logic [POS_W-1:0] POS_SAT  = POS_W'(LINE_BYTES + 1);

	logic [POS_W-1:0] pos_q, pos_e, pos_d, raw;
	logic [7:0]       prev_q, prev_d;
	logic [31:0]      recent_q, recent_e, recent_d;
	logic [15:0]      first_q, first_e, first_d;
	logic [15:0]      silence_q, silence_d;
	logic             err_q, err_e, err_d;
	logic [CS_W-1:0]  cs_q, cs_e, cs_d;
	logic [15:0]      cv_q, cv_e, cv_d;
	logic [15:0]      cvb_q, cvb_e, cvb_d;
	logic             ovf_q, ovf_e, ovf_d;
	logic             gap, line_end;
	logic [7:0]       b, digit;
	logic [15:0]      cv_next;
	alp_kind_t        kind;

	assign b       = item.rx_byte;
	assign gap     = silence_q > gap_limit;
	assign digit   = b - DIGIT_BASE;
	assign cv_next = {cv_e[12:0], 3'b000} + {cv_e[14:0], 1'b0} + {8'h00, digit};

	always_comb begin
		pos_e    = gap ? '0 : pos_q;
		recent_e = gap ? '0 : recent_q;
		first_e  = gap ? '0 : first_q;
		err_e    = gap ? 1'b0 : err_q;
		cs_e     = gap ? '0 : cs_q;
		cv_e     = gap ? '0 : cv_q;
		cvb_e    = gap ? '0 : cvb_q;
		ovf_e    = gap ? 1'b0 : ovf_q;

		line_end = (item.func == FUNC_BYTE) && (pos_e != '0) && (b == CH_LF)
			&& (prev_q == CH_CR);
		raw = pos_e - POS_W'(1);

		if (raw == '0) begin
			kind = KIND_EMPTY;
		end else if (err_e) begin
			kind = KIND_ERROR;
		end else if (raw >= POS_W'(2) && first_e == OK_WORD) begin
			kind = KIND_OK;
		end else begin
			kind = KIND_OTHER;
		end

		res.done               = line_end;
		res.item.line_kind     = kind;
		res.item.line_length   = 8'(raw);
		res.item.error_code    = (kind == KIND_ERROR) ? cvb_e : 16'h0000;
		res.item.line_overflow = ovf_e;
	end

	always_comb begin
		pos_d     = pos_q;
		prev_d    = prev_q;
		recent_d  = recent_q;
		first_d   = first_q;
		silence_d = silence_q;
		err_d     = err_q;
		cs_d      = cs_q;
		cv_d      = cv_q;
		cvb_d     = cvb_q;
		ovf_d     = ovf_q;
		if (fire) begin
			if (item.func == FUNC_TICK) begin
				if (silence_q != 16'hFFFF) begin
					silence_d = silence_q + 16'd1;
				end
			end else begin
				silence_d = '0;
				prev_d    = b;
				if (line_end) begin
					pos_d    = '0;
					recent_d = '0;
					first_d  = '0;
					err_d    = 1'b0;
					cs_d     = '0;
					cv_d     = '0;
					cvb_d    = '0;
					ovf_d    = 1'b0;
				end else begin
					recent_d = recent_e;
					first_d  = first_e;
					err_d    = err_e;
					cs_d     = cs_e;
					cv_d     = cv_e;
					cvb_d    = cv_e;
					ovf_d    = ovf_e || (pos_e >= POS_SAT);
					if (pos_e < POS_CAP) begin
						if (err_e && CS_W'(pos_e) >= cs_e) begin
							cv_d = cv_next;
						end
						if (pos_e == '0) begin
							first_d = {b, 8'h00};
						end else if (pos_e == POS_W'(1)) begin
							first_d = {first_e[15:8], b};
						end
						if (!err_e && recent_e == ERRO_WORD && b == CH_R) begin
							err_d = 1'b1;
							cs_d  = CS_W'(pos_e) + CS_W'(CODE_OFFSET);
						end
						recent_d = {recent_e[23:0], b};
					end
					pos_d = (pos_e < POS_SAT) ? pos_e + POS_W'(1) : pos_e;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			prev_q    <= '0;
			recent_q  <= '0;
			first_q   <= '0;
			silence_q <= '0;
			err_q     <= 1'b0;
			cs_q      <= '0;
			cv_q      <= '0;
			cvb_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			prev_q    <= prev_d;
			recent_q  <= recent_d;
			first_q   <= first_d;
			silence_q <= silence_d;
			err_q     <= err_d;
			cs_q      <= cs_d;
			cv_q      <= cv_d;
			cvb_q     <= cvb_d;
			ovf_q     <= ovf_d;
		end
	end

endmodule

/* design/alp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response line parser port checker
// Result item consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
`include "at_response_line_parser_top_assert.svh"

module alp_checker #(
	parameter int LINE_BYTES = 128
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input alp_pkg::alp_out_t out_data
);
	import alp_pkg::*;

	`ALP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`ALP_ASSERT_NOW(a_code_only_error, out_valid && out_data.line_kind != KIND_ERROR, out_data.error_code == 16'h0000)
	`ALP_ASSERT_NOW(a_empty_clean, out_valid && out_data.line_kind == KIND_EMPTY, out_data.line_length == 8'h00 && !out_data.line_overflow)
	`ALP_ASSERT_NOW(a_ovf_full, out_valid && out_data.line_overflow, out_data.line_length == 8'(LINE_BYTES))

endmodule

bind at_response_line_parser_top alp_checker #(
	.LINE_BYTES (LINE_BYTES)
) u_alp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
